@@ rtl/jac_pkg.sv @@
// ----------------------------------------------------------------------------
// jac_pkg
// Types and constants shared by the joystick axis conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package jac_pkg;

    typedef enum logic [1:0] {
        OP_NORMAL = 2'd0,
        OP_CALIB  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_CAL_MIN     = 3'd0,
        CFG_CAL_MAX     = 3'd1,
        CFG_CENTER_OFS  = 3'd2,
        CFG_RATIO_ABOVE = 3'd3,
        CFG_RATIO_BELOW = 3'd4,
        CFG_THROTTLE    = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POST,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [11:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [15:0] axis_value;
        logic [12:0]        track_low;
        logic [11:0]        track_high;
        logic               is_calibration;
        logic               fault;
    } result_t;

    typedef struct packed {
        logic signed [15:0] val;
        logic               flag;
    } sat_t;

    localparam int SUM_W    = 16;
    localparam int ADC_W    = 12;
    localparam int CFG_W    = 3;
    localparam int CDATA_W  = 16;
    localparam int RATIO_W  = 16;
    localparam int MAG_W    = 26;  // |avg - cal_min| * 1000
    localparam int NORM_W   = MAG_W + 1;
    localparam int DMAG_W   = 28;
    localparam int ACC_W    = DMAG_W + RATIO_W;
    localparam int V_W      = 30;
    localparam int Q_SHIFT  = 15;
    localparam int STEP_W   = 5;

    localparam logic [SUM_W-1:0] MIN_RESET = 16'd4096;
    localparam logic [11:0]      CAL_MAX_RESET = 12'd4095;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd32768;

    localparam logic signed [V_W-1:0] V_SCALE = 30'sd1000;
    localparam logic signed [V_W-1:0] V_MID   = 30'sd1500;
    localparam logic signed [V_W-1:0] V_TOP   = 30'sd2000;
    localparam logic signed [V_W-1:0] V_POS   = 30'sd32767;
    localparam logic signed [V_W-1:0] V_NEG   = -30'sd32768;

endpackage

`default_nettype wire

@@ rtl/joystick_axis_conditioner.sv @@
// ----------------------------------------------------------------------------
// joystick_axis_conditioner
// Averages ADC conversions of one joystick axis, tracks calibration
// extremes and scales the average to a signed 16-bit channel value.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer when
//  item      item_valid item_stall item       in         valid & !stall
//  result    result_valid result_stall result out        valid & !stall
//  cfg       cfg_valid cfg_ready cfg_index    in         valid & ready
//            cfg_data
//
//  An item that completes no average, a clear, a calibration result or a
//  normal average with a divisor of zero or less is done in ST_IDLE.
//  Otherwise a 26-step restoring division runs on the shared adder and
//  ST_POST ends throttle mode; stick mode adds a 16-step shift-add multiply.
//  item_stall is high while the sequencer is busy or a result is held.
//  rst_n clears the accumulator, tracked extremes, sequencer and config.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_axis_conditioner #(
    parameter int AVG_LOG2 = 4,
    parameter int ADC_BITS = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire jac_pkg::item_t           item,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output jac_pkg::result_t              result,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [jac_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [jac_pkg::CDATA_W-1:0] cfg_data
);
    import jac_pkg::*;

    localparam int CNT_W = AVG_LOG2 + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(2 ** AVG_LOG2);
    localparam logic [ADC_W-1:0] SMP_MASK =
        (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);

    // configuration
    logic [11:0]          cal_min_reg, cal_max_reg;
    logic signed [11:0]   ofs_reg;
    logic [RATIO_W-1:0]   rat_hi_reg, rat_lo_reg;
    logic                 thr_reg;

    // control
    state_t               state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rmin_reg, rmin_next;
    logic [SUM_W-1:0]     rmax_reg, rmax_next;
    logic                 rvalid_reg, rvalid_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // datapath
    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [11:0]          rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [DMAG_W-1:0]    dmag_reg, dmag_next;
    logic [RATIO_W-1:0]   mreg_reg, mreg_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    result_t              res_reg, res_next;

    // shared adder
    logic [ACC_W-1:0]     au_a, au_b, au_y;
    logic                 au_sub;

    // combinational terms
    logic                 take;
    logic [ADC_W-1:0]     smp;
    logic [SUM_W-1:0]     sum_add, avg;
    logic [CNT_W-1:0]     cnt_inc;
    logic signed [16:0]   diff;
    logic [15:0]          dmag16;
    logic [MAG_W-1:0]     num_mag;
    logic signed [12:0]   den;
    logic                 den_ok;
    logic [SUM_W-1:0]     new_min, new_max;
    logic [12:0]          div_sh;
    logic                 div_ge;
    logic signed [NORM_W-1:0] norm;
    logic signed [V_W-1:0]    norm_v, ofs_v, thr_v, stk_v, dev, dev_abs;
    logic signed [V_W-1:0]    q_v, sq_v, fin_v;
    sat_t                 sat_thr, sat_fin;

    function automatic sat_t sat16(input logic signed [V_W-1:0] v);
        sat_t r;
        r.flag = 1'b0;
        if (v > V_POS) begin
            r.val  = 16'sh7FFF;
            r.flag = 1'b1;
        end else if (v < V_NEG) begin
            r.val  = -16'sh8000;
            r.flag = 1'b1;
        end else begin
            r.val = v[15:0];
        end
        return r;
    endfunction

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE) || rvalid_reg;
    assign result_valid = rvalid_reg;
    assign result       = res_reg;
    assign take         = item_valid && !item_stall;

    assign au_y = au_sub ? (au_a - au_b) : (au_a + au_b);

    always_comb
    begin
        smp      = item.sample & SMP_MASK;
        sum_add  = sum_reg + SUM_W'(smp);
        cnt_inc  = cnt_reg + CNT_W'(1);
        avg      = sum_add >> AVG_LOG2;
        diff     = $signed({1'b0, avg}) - $signed({5'b0, cal_min_reg});
        dmag16   = diff[16] ? 16'(-diff) : diff[15:0];
        num_mag  = (MAG_W'(dmag16) << 10) - (MAG_W'(dmag16) << 4)
                 - (MAG_W'(dmag16) << 3);
        den      = $signed({1'b0, cal_max_reg}) - $signed({1'b0, cal_min_reg});
        den_ok   = !den[12] && (den != 13'sd0);
        new_min  = (avg < rmin_reg) ? avg : rmin_reg;
        new_max  = (avg > rmax_reg) ? avg : rmax_reg;

        div_sh   = {rem_reg, quo_reg[MAG_W-1]};
        div_ge   = 1'b0;

        norm     = neg_reg ? -$signed(NORM_W'(quo_reg)) : $signed(NORM_W'(quo_reg));
        norm_v   = V_W'(norm);
        ofs_v    = V_W'(ofs_reg);
        thr_v    = V_TOP - norm_v - ofs_v;
        if (thr_v < V_SCALE)
            thr_v = V_SCALE;
        sat_thr  = sat16(thr_v);
        stk_v    = norm_v + V_SCALE - ofs_v;
        dev      = stk_v - V_MID;
        dev_abs  = dev[V_W-1] ? -dev : dev;

        q_v      = $signed(V_W'(acc_reg[ACC_W-1:Q_SHIFT]));
        sq_v     = neg_reg ? -q_v : q_v;
        fin_v    = sq_v + V_MID;
        sat_fin  = sat16(fin_v);

        au_a     = '0;
        au_b     = '0;
        au_sub   = 1'b0;

        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        rmin_next   = rmin_reg;
        rmax_next   = rmax_reg;
        rvalid_next = rvalid_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        dmag_next   = dmag_reg;
        mreg_next   = mreg_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;

        if (rvalid_reg && !result_stall)
            rvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take) begin
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            rmin_next = MIN_RESET;
                            rmax_next = '0;
                        end
                        OP_NORMAL, OP_CALIB:
                        begin
                            sum_next = sum_add;
                            cnt_next = cnt_inc;
                            if (cnt_inc == CNT_FULL) begin
                                sum_next = '0;
                                cnt_next = '0;
                                if (item.operation == OP_CALIB) begin
                                    rmin_next              = new_min;
                                    rmax_next              = new_max;
                                    res_next.axis_value    = '0;
                                    res_next.track_low     = new_min[12:0];
                                    res_next.track_high    = new_max[11:0];
                                    res_next.is_calibration = 1'b1;
                                    res_next.fault         = 1'b0;
                                    rvalid_next            = 1'b1;
                                end else if (!den_ok) begin
                                    res_next.axis_value    = diff[16] ? -16'sh8000
                                                                      : 16'sh7FFF;
                                    res_next.track_low     = rmin_reg[12:0];
                                    res_next.track_high    = rmax_reg[11:0];
                                    res_next.is_calibration = 1'b0;
                                    res_next.fault         = 1'b1;
                                    rvalid_next            = 1'b1;
                                end else begin
                                    quo_next   = num_mag;
                                    rem_next   = '0;
                                    neg_next   = diff[16];
                                    step_next  = '0;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                au_a     = ACC_W'(div_sh);
                au_b     = ACC_W'(den[11:0]);
                au_sub   = 1'b1;
                div_ge   = !au_y[ACC_W-1];
                rem_next = div_ge ? au_y[11:0] : div_sh[11:0];
                quo_next = {quo_reg[MAG_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MAG_W - 1))
                    state_next = ST_POST;
            end

            ST_POST:
            begin
                if (thr_reg) begin
                    res_next.axis_value     = sat_thr.val;
                    res_next.track_low      = rmin_reg[12:0];
                    res_next.track_high     = rmax_reg[11:0];
                    res_next.is_calibration = 1'b0;
                    res_next.fault          = sat_thr.flag;
                    rvalid_next             = 1'b1;
                    state_next              = ST_IDLE;
                end else begin
                    dmag_next  = dev_abs[DMAG_W-1:0];
                    neg_next   = dev[V_W-1];
                    mreg_next  = (stk_v > V_MID) ? rat_hi_reg : rat_lo_reg;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                au_a      = acc_reg << 1;
                au_b      = mreg_reg[RATIO_W-1] ? ACC_W'(dmag_reg) : '0;
                au_sub    = 1'b0;
                acc_next  = au_y;
                mreg_next = mreg_reg << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RATIO_W - 1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                res_next.axis_value     = sat_fin.val;
                res_next.track_low      = rmin_reg[12:0];
                res_next.track_high     = rmax_reg[11:0];
                res_next.is_calibration = 1'b0;
                res_next.fault          = sat_fin.flag;
                rvalid_next             = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            rmin_reg   <= MIN_RESET;
            rmax_reg   <= '0;
            rvalid_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            rmin_reg   <= rmin_next;
            rmax_reg   <= rmax_next;
            rvalid_reg <= rvalid_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        dmag_reg <= dmag_next;
        mreg_reg <= mreg_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cal_min_reg <= '0;
            cal_max_reg <= CAL_MAX_RESET;
            ofs_reg     <= '0;
            rat_hi_reg  <= RATIO_RESET;
            rat_lo_reg  <= RATIO_RESET;
            thr_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CAL_MIN:     cal_min_reg <= cfg_data[11:0];
                CFG_CAL_MAX:     cal_max_reg <= cfg_data[11:0];
                CFG_CENTER_OFS:  ofs_reg     <= $signed(cfg_data[11:0]);
                CFG_RATIO_ABOVE: rat_hi_reg  <= cfg_data;
                CFG_RATIO_BELOW: rat_lo_reg  <= cfg_data;
                CFG_THROTTLE:    thr_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
